/* rtl/core/gmtz_pkg.sv */
// ----------------------------------------------------------------------------
// gmtz_pkg
// Shared types, constants and helper functions for the grid path block.
// ----------------------------------------------------------------------------
package gmtz_pkg;

	// Field widths
	localparam int VAL_W   = 20;   // cell value
	localparam int TRK_W   = 16;   // track value
	localparam int FIVES_W = 4;    // factors of five in a 20-bit value (max 8)
	localparam int TWOS_W  = 5;    // factors of two in a 20-bit value (max 19)
	localparam int CFG_W   = 11;   // grid_size register

	// Blocked marker; sums saturate to it
	localparam logic [TRK_W-1:0] BLOCKED = 16'hFFFF;

	// Divisibility by five: v * inv(5) mod 2^20 is v/5 when 5 divides v,
	// and 5 divides v exactly when that product is at most (2^20-1)/5.
	localparam logic [VAL_W-1:0] INV5     = 20'hCCCCD;
	localparam logic [VAL_W-1:0] DIV5_LIM = 20'd209715;

	// Sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_WORK
	} state_t;

	// Status from the factor unit to the sequencer
	typedef struct packed {
		logic               zero;   // cell value is zero
		logic               more;   // another factor of five remains
		logic [FIVES_W-1:0] fives;
		logic [TWOS_W-1:0]  twos;
	} fact_stat_t;

	// Trailing zero count of a cell value
	function automatic logic [TWOS_W-1:0] trail_zeros(input logic [VAL_W-1:0] v);
		logic [TWOS_W-1:0] tz;
		tz = '0;
		for (int i = VAL_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				tz = TWOS_W'(i);
			end
		end
		return tz;
	endfunction

	// Track update: smaller neighbor plus own count, saturating at BLOCKED
	function automatic logic [TRK_W-1:0] track(input logic [TWOS_W-1:0] cnt,
		input logic [TRK_W-1:0] left, input logic [TRK_W-1:0] up);
		logic [TRK_W-1:0] best;
		logic [TRK_W:0]   sum;
		best = (left < up) ? left : up;
		sum  = {1'b0, best} + {{(TRK_W + 1 - TWOS_W){1'b0}}, cnt};
		if (best == BLOCKED || sum >= {1'b0, BLOCKED}) begin
			return BLOCKED;
		end
		return sum[TRK_W-1:0];
	endfunction

endpackage

/* rtl/core/gmtz_row_mem.sv */
// ----------------------------------------------------------------------------
// gmtz_row_mem
// Row store: one entry per column holding the fives and twos track values of
// the row above. Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module gmtz_row_mem #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/gmtz_factor.sv */
// ----------------------------------------------------------------------------
// gmtz_factor
// Factor counter for one cell: trailing zeros give the twos count at load,
// then one factor of five is divided out per step.
// ----------------------------------------------------------------------------
module gmtz_factor (
	input  logic                        clk,
	input  logic                        load,
	input  logic                        step,
	input  logic [gmtz_pkg::VAL_W-1:0]  value,
	output gmtz_pkg::fact_stat_t        stat
);
	import gmtz_pkg::*;

	logic [VAL_W-1:0]   v_q;
	logic [FIVES_W-1:0] fives_q;
	logic [TWOS_W-1:0]  twos_q;
	logic [2*VAL_W-1:0] prod;
	logic [VAL_W-1:0]   quot;

	// exact quotient by five when divisible
	assign prod = v_q * INV5;
	assign quot = prod[VAL_W-1:0];

	// working registers
	always_ff @(posedge clk) begin
		if (load) begin
			v_q     <= value;
			fives_q <= '0;
			twos_q  <= trail_zeros(value);
		end else if (step) begin
			v_q     <= quot;
			fives_q <= fives_q + FIVES_W'(1);
		end
	end

	// status
	always_comb begin
		stat.zero  = (v_q == '0);
		stat.more  = (v_q != '0) && (quot <= DIV5_LIM);
		stat.fives = fives_q;
		stat.twos  = twos_q;
	end

endmodule

/* rtl/core/grid_min_trailing_zeros_path.sv */
// ----------------------------------------------------------------------------
// grid_min_trailing_zeros_path
// Minimum fives/twos path over a streamed square grid, right and down moves.
// ----------------------------------------------------------------------------
// Each cell is taken in idle; the factor unit then divides out one factor of
// five per step, F being the factors of five in the cell value (0..8), and no
// new cell is taken until the current one finishes.
// The result is shown the cycle after the last cell of the grid finishes and
// waits in an output register; the next grid may start meanwhile.
// Reset: grid size 1, position 0, left values blocked, no result pending.
module grid_min_trailing_zeros_path #(
	parameter int MAX_SIZE = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// config: grid_size
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // [19:0] cell_value
	// output stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] min_factor_count
	output logic        m_axis_tuser    // [0] no_path
);
	import gmtz_pkg::*;

	localparam int CW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int SW = $clog2(MAX_SIZE + 1);
	localparam logic [SW-1:0] SIZE_MAX = SW'(MAX_SIZE);

	state_t             state_q, state_nx;
	logic [SW-1:0]      size_q;
	logic [SW-1:0]      size_nx;
	logic [CW-1:0]      col_q, row_q;
	logic [TRK_W-1:0]   left5_q, left2_q;
	logic               out_valid_q;
	logic [TRK_W-1:0]   out_count_q;
	logic               out_nopath_q;

	logic               accept;
	logic               out_free;
	logic               last_col, last_row, last_cell;
	logic               finish, step;
	logic [TRK_W-1:0]   up5, up2, f5, f2, fmin;
	logic [2*TRK_W-1:0] rd_data;
	fact_stat_t         fstat;

	// effective size of a config write
	always_comb begin
		if (cfg_wdata == '0) begin
			size_nx = SW'(1);
		end else if (32'(cfg_wdata) > MAX_SIZE) begin
			size_nx = SIZE_MAX;
		end else begin
			size_nx = SW'(cfg_wdata);
		end
	end

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;

	// position
	assign last_col  = (SW'(col_q) + SW'(1)) == size_q;
	assign last_row  = (SW'(row_q) + SW'(1)) == size_q;
	assign last_cell = last_col && last_row;

	// factor unit
	gmtz_factor u_factor (
		.clk   (clk),
		.load  (accept),
		.step  (step),
		.value (s_axis_tdata[VAL_W-1:0]),
		.stat  (fstat)
	);

	// row store, read at request, written when the cell finishes
	gmtz_row_mem #(
		.DEPTH  (MAX_SIZE),
		.ADDR_W (CW),
		.DATA_W (2 * TRK_W)
	) u_row_mem (
		.clk   (clk),
		.we    (finish),
		.waddr (col_q),
		.wdata ({f5, f2}),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_data)
	);

	// upper neighbor, virtual row above the grid
	always_comb begin
		if (row_q == '0) begin
			up5 = (col_q == '0) ? '0 : BLOCKED;
			up2 = up5;
		end else begin
			up5 = rd_data[2*TRK_W-1:TRK_W];
			up2 = rd_data[TRK_W-1:0];
		end
	end

	// track values of the current cell
	always_comb begin
		if (fstat.zero) begin
			f5 = BLOCKED;
			f2 = BLOCKED;
		end else begin
			f5 = track(TWOS_W'(fstat.fives), left5_q, up5);
			f2 = track(fstat.twos, left2_q, up2);
		end
		fmin = (f5 < f2) ? f5 : f2;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nx = ST_WORK;
				end
			end
			ST_WORK: begin
				if (finish) begin
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready = 1'b0;
		step          = 1'b0;
		finish        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_WORK: begin
				step   = fstat.more;
				finish = !fstat.more && (!last_cell || out_free);
			end
			default: ;
		endcase
	end

	// state, size and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			size_q  <= SW'(1);
			col_q   <= '0;
			row_q   <= '0;
			left5_q <= BLOCKED;
			left2_q <= BLOCKED;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				size_q  <= size_nx;
				col_q   <= '0;
				row_q   <= '0;
				left5_q <= BLOCKED;
				left2_q <= BLOCKED;
			end else if (finish) begin
				if (last_col) begin
					col_q   <= '0;
					left5_q <= BLOCKED;
					left2_q <= BLOCKED;
					row_q   <= last_row ? '0 : row_q + CW'(1);
				end else begin
					col_q   <= col_q + CW'(1);
					left5_q <= f5;
					left2_q <= f2;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish && last_cell) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish && last_cell) begin
			out_nopath_q <= (fmin == BLOCKED);
			out_count_q  <= (fmin == BLOCKED) ? '0 : fmin;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_count_q;
	assign m_axis_tuser  = out_nopath_q;

endmodule
